// ===== src/lmtc_pkg.sv =====
// ----------------------------------------------------------------------------
// lmtc_pkg
// Shared types, timing constants and codes for the LCD mode/timing controller.
// ----------------------------------------------------------------------------
package lmtc_pkg;

  localparam int unsigned DOT_W      = 10;
  localparam int unsigned LINE_W     = 8;
  localparam int unsigned CYC_W      = 7;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // dot and line timing
  localparam logic [DOT_W-1:0]  DOTS_OAM    = 10'd80;
  localparam logic [DOT_W-1:0]  DOTS_DRAW   = 10'd172;
  localparam logic [DOT_W-1:0]  DOTS_HBLANK = 10'd204;
  localparam logic [DOT_W-1:0]  DOTS_LINE   = 10'd456;
  localparam logic [DOT_W-1:0]  DMA_LENGTH  = 10'd640;
  localparam logic [LINE_W-1:0] LINE_VBLANK = 8'd144;
  localparam logic [LINE_W-1:0] LINES_FRAME = 8'd154;

  // mode codes as seen on the result port
  localparam logic [MODE_W-1:0] MODE_HBLANK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VBLANK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OAM    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DRAW   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LCD_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COMPARE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEL_HBLANK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEL_VBLANK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEL_OAM      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SEL_COINC    = 3'd5;

  typedef enum logic [3:0] {
    ST_HBLANK = 4'b0001,
    ST_VBLANK = 4'b0010,
    ST_OAM    = 4'b0100,
    ST_DRAW   = 4'b1000
  } lcd_state_t;

  typedef struct packed {
    logic              lcd_enable;
    logic [LINE_W-1:0] line_compare;
    logic              sel_hblank;
    logic              sel_vblank;
    logic              sel_oam;
    logic              sel_coinc;
  } cfg_t;

  typedef struct packed {
    logic             action;
    logic [CYC_W-1:0] cycles;
  } item_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [LINE_W-1:0] line;
    logic              line_match;
    logic              vblank_irq;
    logic              stat_irq;
    logic              render_line;
    logic              dma_busy;
    logic              vram_open;
    logic              oam_open;
  } result_t;

  function automatic logic [MODE_W-1:0] mode_code(input lcd_state_t st);
    logic [MODE_W-1:0] code;
    case (st)
      ST_HBLANK: code = MODE_HBLANK;
      ST_VBLANK: code = MODE_VBLANK;
      ST_OAM:    code = MODE_OAM;
      ST_DRAW:   code = MODE_DRAW;
      default:   code = MODE_HBLANK;
    endcase
    return code;
  endfunction

endpackage

// ===== src/lmtc_cfg.sv =====
// ----------------------------------------------------------------------------
// lmtc_cfg
// Configuration register file, write-only, one register per index.
// ----------------------------------------------------------------------------
module lmtc_cfg import lmtc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LCD_ENABLE:   cfg_nxt.lcd_enable   = cfg_wdata[0];
        CFG_LINE_COMPARE: cfg_nxt.line_compare = cfg_wdata[LINE_W-1:0];
        CFG_SEL_HBLANK:   cfg_nxt.sel_hblank   = cfg_wdata[0];
        CFG_SEL_VBLANK:   cfg_nxt.sel_vblank   = cfg_wdata[0];
        CFG_SEL_OAM:      cfg_nxt.sel_oam      = cfg_wdata[0];
        CFG_SEL_COINC:    cfg_nxt.sel_coinc    = cfg_wdata[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/lmtc_in_reg.sv =====
// ----------------------------------------------------------------------------
// lmtc_in_reg
// Input register stage: holds one accepted transaction until it is stepped.
// ----------------------------------------------------------------------------
module lmtc_in_reg import lmtc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_action,
  input  logic [CYC_W-1:0] in_cycles,
  input  logic             step_en,
  output logic             item_vld,
  output item_t            item
);

  logic  vld_r;
  logic  vld_nxt;
  item_t item_r;
  logic  load;

  // slot frees up in the same cycle the held item is stepped
  assign in_ready = !vld_r || step_en;
  assign load     = in_valid && in_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (step_en) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.action <= in_action;
      item_r.cycles <= in_cycles;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

// ===== src/lmtc_seq.sv =====
// ----------------------------------------------------------------------------
// lmtc_seq
// Mode/timing state and its single-step update; at most one mode change
// per transaction.
// ----------------------------------------------------------------------------
module lmtc_seq import lmtc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    step_en,
  input  item_t   item,
  output result_t res
);

  lcd_state_t        state_r,  state_nxt;
  logic [DOT_W-1:0]  dot_r,    dot_nxt;
  logic [LINE_W-1:0] line_r,   line_nxt;
  logic              match_r,  match_nxt;
  logic [DOT_W-1:0]  dma_r,    dma_nxt;

  logic [DOT_W-1:0]  cyc_ext;
  logic [DOT_W-1:0]  dot_sum;
  logic [LINE_W-1:0] line_inc;
  logic              inc_match;
  logic              vb;
  logic              st;
  logic              rl;

  assign cyc_ext   = {{(DOT_W-CYC_W){1'b0}}, item.cycles};
  assign dot_sum   = dot_r + cyc_ext;
  assign line_inc  = line_r + 8'd1;
  assign inc_match = (line_inc == cfg.line_compare);

  always_comb begin
    state_nxt = state_r;
    dot_nxt   = dot_r;
    line_nxt  = line_r;
    match_nxt = match_r;
    dma_nxt   = dma_r;
    vb        = 1'b0;
    st        = 1'b0;
    rl        = 1'b0;
    if (item.action) begin
      dma_nxt = DMA_LENGTH;
    end else if (!cfg.lcd_enable) begin
      dot_nxt   = '0;
      line_nxt  = '0;
      state_nxt = ST_HBLANK;
    end else begin
      dma_nxt = (dma_r > cyc_ext) ? dma_r - cyc_ext : '0;
      dot_nxt = dot_sum;
      case (state_r)
        ST_OAM: begin
          if (dot_sum >= DOTS_OAM) begin
            dot_nxt   = dot_sum - DOTS_OAM;
            state_nxt = ST_DRAW;
          end
        end
        ST_DRAW: begin
          if (dot_sum >= DOTS_DRAW) begin
            dot_nxt   = dot_sum - DOTS_DRAW;
            state_nxt = ST_HBLANK;
            rl        = 1'b1;
            st        = cfg.sel_hblank;
          end
        end
        ST_HBLANK: begin
          if (dot_sum >= DOTS_HBLANK) begin
            dot_nxt   = dot_sum - DOTS_HBLANK;
            line_nxt  = line_inc;
            match_nxt = inc_match;
            if (line_inc == LINE_VBLANK) begin
              state_nxt = ST_VBLANK;
              vb        = 1'b1;
              st        = (inc_match && cfg.sel_coinc) || cfg.sel_vblank;
            end else begin
              state_nxt = ST_OAM;
              st        = (inc_match && cfg.sel_coinc) || cfg.sel_oam;
            end
          end
        end
        ST_VBLANK: begin
          if (dot_sum >= DOTS_LINE) begin
            dot_nxt   = dot_sum - DOTS_LINE;
            match_nxt = inc_match;
            // match is taken on the transient end-of-frame count too
            if (line_inc >= LINES_FRAME) begin
              line_nxt  = '0;
              state_nxt = ST_OAM;
              st        = (inc_match && cfg.sel_coinc) || cfg.sel_oam;
            end else begin
              line_nxt  = line_inc;
              st        = inc_match && cfg.sel_coinc;
            end
          end
        end
        default: state_nxt = state_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_OAM;
      dot_r   <= '0;
      line_r  <= '0;
      match_r <= 1'b0;
      dma_r   <= '0;
    end else if (step_en) begin
      state_r <= state_nxt;
      dot_r   <= dot_nxt;
      line_r  <= line_nxt;
      match_r <= match_nxt;
      dma_r   <= dma_nxt;
    end
  end

  always_comb begin
    res.mode        = mode_code(state_nxt);
    res.line        = line_nxt;
    res.line_match  = match_nxt;
    res.vblank_irq  = vb;
    res.stat_irq    = st;
    res.render_line = rl;
    res.dma_busy    = (dma_nxt != '0);
    res.vram_open   = (state_nxt != ST_DRAW) && (dma_nxt == '0);
    res.oam_open    = (state_nxt == ST_HBLANK) || (state_nxt == ST_VBLANK);
  end

endmodule

// ===== src/lmtc_out_reg.sv =====
// ----------------------------------------------------------------------------
// lmtc_out_reg
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module lmtc_out_reg import lmtc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  output logic    slot_free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    vld_r;
  logic    vld_nxt;
  result_t res_r;

  assign slot_free = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

// ===== src/lcd_mode_timing_controller.sv =====
// ----------------------------------------------------------------------------
// lcd_mode_timing_controller
// LCD mode/timing sequencer: OAM scan, drawing, hblank, vblank, line count,
// line compare, interrupt pulses, OAM DMA countdown and access flags.
// ----------------------------------------------------------------------------
// Path: an accepted transaction is stepped from the input reg into the result
//   reg, which raises out_valid; a full result reg holds it in the input reg.
// Throughput: 1 transaction per cycle while out_ready is high; one pass of adds
//   and compares on the 10-bit dot counter sits between input and result regs.
// Reset: synchronous, active low; both stages empty, mode OAM scan, line 0,
//   counters and configuration cleared. No clearing pass.
module lcd_mode_timing_controller import lmtc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [CYC_W-1:0]      in_cycles,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [MODE_W-1:0]     out_mode,
  output logic [LINE_W-1:0]     out_line,
  output logic                  out_line_match,
  output logic                  out_vblank_irq,
  output logic                  out_stat_irq,
  output logic                  out_render_line,
  output logic                  out_dma_busy,
  output logic                  out_vram_open,
  output logic                  out_oam_open,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg;
  item_t   item;
  logic    item_vld;
  logic    slot_free;
  logic    step_en;
  result_t res;
  result_t out_res;

  assign step_en = item_vld && slot_free;

  lmtc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lmtc_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .in_cycles (in_cycles),
    .step_en   (step_en),
    .item_vld  (item_vld),
    .item      (item)
  );

  lmtc_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .step_en (step_en),
    .item    (item),
    .res     (res)
  );

  lmtc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_en),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_mode        = out_res.mode;
  assign out_line        = out_res.line;
  assign out_line_match  = out_res.line_match;
  assign out_vblank_irq  = out_res.vblank_irq;
  assign out_stat_irq    = out_res.stat_irq;
  assign out_render_line = out_res.render_line;
  assign out_dma_busy    = out_res.dma_busy;
  assign out_vram_open   = out_res.vram_open;
  assign out_oam_open    = out_res.oam_open;

endmodule

// ===== src/lmtc_checker.sv =====
// ----------------------------------------------------------------------------
// lmtc_checker
// Port-level checks for the LCD mode/timing controller, bound to the top.
// ----------------------------------------------------------------------------
module lmtc_checker import lmtc_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [MODE_W-1:0]     out_mode,
  input logic [LINE_W-1:0]     out_line,
  input logic                  out_vblank_irq,
  input logic                  out_render_line,
  input logic                  out_dma_busy,
  input logic                  out_vram_open,
  input logic                  out_oam_open
);

  // both stages come up empty after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_valid && in_ready))
    else $error("pipeline not empty after reset");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_mode) && $stable(out_line) && $stable(out_dma_busy)))
    else $error("stalled result changed");

  // vblank pulse only on entry to vblank at the first vblank line
  a_vblank_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_vblank_irq) |-> (out_mode == MODE_VBLANK && out_line == LINE_VBLANK))
    else $error("vblank pulse outside vblank entry");

  // render trigger lands in hblank, where OAM is open
  a_render_hblank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_render_line) |-> (out_mode == MODE_HBLANK && out_oam_open))
    else $error("render pulse outside hblank");

  // VRAM access flag consistent with mode and DMA state
  a_vram_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_vram_open == (!out_dma_busy && out_mode != MODE_DRAW)))
    else $error("vram_open inconsistent");

endmodule

bind lcd_mode_timing_controller lmtc_checker u_lmtc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_mode        (out_mode),
  .out_line        (out_line),
  .out_vblank_irq  (out_vblank_irq),
  .out_render_line (out_render_line),
  .out_dma_busy    (out_dma_busy),
  .out_vram_open   (out_vram_open),
  .out_oam_open    (out_oam_open)
);

// ===== bench/lmtc_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lmtc_scoreboard
// Watches the input, result and configuration ports of the LCD mode/timing
// controller, keeps its own copy of the timing state and configuration,
// forecasts every result and compares it field by field when it is accepted.
// ----------------------------------------------------------------------------
module lmtc_scoreboard import lmtc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_action,
  input  logic [CYC_W-1:0]      in_cycles,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [MODE_W-1:0]     out_mode,
  input  logic [LINE_W-1:0]     out_line,
  input  logic                  out_line_match,
  input  logic                  out_vblank_irq,
  input  logic                  out_stat_irq,
  input  logic                  out_render_line,
  input  logic                  out_dma_busy,
  input  logic                  out_vram_open,
  input  logic                  out_oam_open,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           mismatch_count,
  output int unsigned           results_owed
);

  cfg_t              shadow_cfg;
  logic [MODE_W-1:0] mode_q;
  logic [DOT_W-1:0]  dots_q;
  logic [LINE_W-1:0] line_q;
  logic              match_q;
  logic [DOT_W-1:0]  dma_q;
  result_t           timing_expected[$];

  initial begin
    mismatch_count = 0;
    results_owed   = 0;
  end

  function automatic logic mode_irq_sel(input logic [MODE_W-1:0] m);
    case (m)
      MODE_HBLANK: return shadow_cfg.sel_hblank;
      MODE_VBLANK: return shadow_cfg.sel_vblank;
      MODE_OAM:    return shadow_cfg.sel_oam;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic logic enter_mode(input logic [MODE_W-1:0] m);
    mode_q = m;
    return mode_irq_sel(m);
  endfunction

  // coincidence is only evaluated on an increment, including the count 154
  function automatic logic bump_line();
    line_q  = line_q + 1'b1;
    match_q = (line_q == shadow_cfg.line_compare);
    return match_q & shadow_cfg.sel_coinc;
  endfunction

  function automatic result_t timing_step(input logic act, input logic [CYC_W-1:0] cyc);
    result_t r;
    logic    vb;
    logic    st;
    logic    rl;
    vb = 1'b0;
    st = 1'b0;
    rl = 1'b0;
    if (act) begin
      dma_q = DMA_LENGTH;
    end else if (!shadow_cfg.lcd_enable) begin
      dots_q = '0;
      line_q = '0;
      mode_q = MODE_HBLANK;
    end else begin
      if (dma_q > cyc) dma_q = dma_q - cyc;
      else dma_q = '0;
      dots_q = dots_q + cyc;
      // one transition per step; leftover dots carry over
      case (mode_q)
        MODE_OAM: begin
          if (dots_q >= DOTS_OAM) begin
            dots_q = dots_q - DOTS_OAM;
            st = st | enter_mode(MODE_DRAW);
          end
        end
        MODE_DRAW: begin
          if (dots_q >= DOTS_DRAW) begin
            dots_q = dots_q - DOTS_DRAW;
            rl = 1'b1;
            st = st | enter_mode(MODE_HBLANK);
          end
        end
        MODE_HBLANK: begin
          if (dots_q >= DOTS_HBLANK) begin
            dots_q = dots_q - DOTS_HBLANK;
            st = st | bump_line();
            if (line_q == LINE_VBLANK) begin
              st = st | enter_mode(MODE_VBLANK);
              vb = 1'b1;
            end else begin
              st = st | enter_mode(MODE_OAM);
            end
          end
        end
        default: begin
          if (dots_q >= DOTS_LINE) begin
            dots_q = dots_q - DOTS_LINE;
            st = st | bump_line();
            if (line_q >= LINES_FRAME) begin
              line_q = '0;
              st = st | enter_mode(MODE_OAM);
            end
          end
        end
      endcase
    end
    r.mode        = mode_q;
    r.line        = line_q;
    r.line_match  = match_q;
    r.vblank_irq  = vb;
    r.stat_irq    = st;
    r.render_line = rl;
    r.dma_busy    = (dma_q != '0);
    r.vram_open   = (mode_q != MODE_DRAW) && (dma_q == '0);
    r.oam_open    = (mode_q == MODE_HBLANK) || (mode_q == MODE_VBLANK);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      shadow_cfg = '0;
      mode_q     = MODE_OAM;
      dots_q     = '0;
      line_q     = '0;
      match_q    = 1'b0;
      dma_q      = '0;
      timing_expected.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_LCD_ENABLE:   shadow_cfg.lcd_enable   = cfg_wdata[0];
          CFG_LINE_COMPARE: shadow_cfg.line_compare = cfg_wdata[LINE_W-1:0];
          CFG_SEL_HBLANK:   shadow_cfg.sel_hblank   = cfg_wdata[0];
          CFG_SEL_VBLANK:   shadow_cfg.sel_vblank   = cfg_wdata[0];
          CFG_SEL_OAM:      shadow_cfg.sel_oam      = cfg_wdata[0];
          CFG_SEL_COINC:    shadow_cfg.sel_coinc    = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        timing_expected = {timing_expected, timing_step(in_action, in_cycles)};
      if (out_valid && out_ready) begin
        if (timing_expected.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with no transaction pending: expected none, %s %0d line %0d",
                   $time, "actual mode", out_mode, out_line);
        end else begin
          want = timing_expected.pop_front();
          check_field("mode",        8'(want.mode),        8'(out_mode));
          check_field("line",        want.line,            out_line);
          check_field("line_match",  8'(want.line_match),  8'(out_line_match));
          check_field("vblank_irq",  8'(want.vblank_irq),  8'(out_vblank_irq));
          check_field("stat_irq",    8'(want.stat_irq),    8'(out_stat_irq));
          check_field("render_line", 8'(want.render_line), 8'(out_render_line));
          check_field("dma_busy",    8'(want.dma_busy),    8'(out_dma_busy));
          check_field("vram_open",   8'(want.vram_open),   8'(out_vram_open));
          check_field("oam_open",    8'(want.oam_open),    8'(out_oam_open));
        end
      end
    end
    results_owed = timing_expected.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the LCD mode/timing controller: a directed walk
// through the mode sequence and DMA, then long random runs over several
// configurations with random idling on both sides and a long result stall.
// ----------------------------------------------------------------------------
module testbench;
  import lmtc_pkg::*;

  localparam int unsigned STALL_LIMIT     = 3000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int          DMA_MARK        = -1;
  // directed walk from hblank line 0: OAM, draw, hblank edges, DMA run-down
  localparam int DIRECTED_SEQ [18] = '{80, 80, 80, 0, 80, DMA_MARK, 80, 80, 80,
                                       80, 64, 80, 80, 80, 4, 80, 80, 44};

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_action;
  logic [CYC_W-1:0]      in_cycles;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [MODE_W-1:0]     out_mode;
  logic [LINE_W-1:0]     out_line;
  logic                  out_line_match;
  logic                  out_vblank_irq;
  logic                  out_stat_irq;
  logic                  out_render_line;
  logic                  out_dma_busy;
  logic                  out_vram_open;
  logic                  out_oam_open;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned mismatch_count;
  int unsigned results_owed;
  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_taken = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lcd_mode_timing_controller dut (.*);

  lmtc_scoreboard timing_check (.*);

  // result side: random back-pressure, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_left  = HOLD_OFF_CYCLES;
      hold_taken = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("lcd_mode_timing_controller verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic act, input logic [CYC_W-1:0] cyc);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_cycles <= cyc;
    do @(posedge clk); while (!in_ready);
  endtask

  // mostly long advances so the random runs get through a whole frame
  task automatic send_random();
    logic [CYC_W-1:0] cyc;
    if ($urandom_range(99) < 4) begin
      send_item(1'b1, CYC_W'($urandom_range(80)));
    end else begin
      if ($urandom_range(9) == 0) cyc = CYC_W'($urandom_range(80));
      else cyc = CYC_W'($urandom_range(80, 72));
      send_item(1'b0, cyc);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // sels = {hblank, vblank, oam, coincidence}
  task automatic program_cfg(input logic en, input logic [LINE_W-1:0] cmp,
                             input logic [3:0] sels);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_LCD_ENABLE;
    cfg_wdata <= CFG_DATA_W'(en);
    @(posedge clk);
    cfg_index <= CFG_LINE_COMPARE;
    cfg_wdata <= cmp;
    @(posedge clk);
    cfg_index <= CFG_SEL_HBLANK;
    cfg_wdata <= CFG_DATA_W'(sels[3]);
    @(posedge clk);
    cfg_index <= CFG_SEL_VBLANK;
    cfg_wdata <= CFG_DATA_W'(sels[2]);
    @(posedge clk);
    cfg_index <= CFG_SEL_OAM;
    cfg_wdata <= CFG_DATA_W'(sels[1]);
    @(posedge clk);
    cfg_index <= CFG_SEL_COINC;
    cfg_wdata <= CFG_DATA_W'(sels[0]);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_action <= 1'b0;
    in_cycles <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_LCD_ENABLE;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // LCD off: DMA start shows the reset mode, advances pin hblank at line 0
    send_item(1'b1, 7'd80);
    send_item(1'b0, 7'd0);
    send_item(1'b0, 7'd80);
    wait_idle();

    program_cfg(1'b1, 8'd1, 4'b1111);
    foreach (DIRECTED_SEQ[k]) begin
      if (DIRECTED_SEQ[k] == DMA_MARK) send_item(1'b1, 7'd5);
      else send_item(1'b0, CYC_W'(DIRECTED_SEQ[k]));
    end
    wait_idle();

    send_gap_pct = 34;
    recv_gap_pct = 70;
    program_cfg(1'b1, 8'd0, 4'($urandom_range(15)));
    repeat (250) send_random();
    wait_idle();

    send_gap_pct = 70;
    recv_gap_pct = 34;
    program_cfg(1'b1, LINE_W'($urandom_range(153, 1)), 4'($urandom_range(15)));
    repeat (250) send_random();
    wait_idle();

    // no idling; long result stall so the block backs up into its input
    send_gap_pct = 0;
    recv_gap_pct = 0;
    program_cfg(1'b1, LINES_FRAME, {3'($urandom_range(7)), 1'b1});
    hold_req = 1'b1;
    repeat (300) send_random();
    wait_idle();

    program_cfg(1'b1, 8'd255, 4'b1111);
    repeat (30) send_random();
    wait_idle();
    program_cfg(1'b0, 8'd255, 4'b1111);
    repeat (10) send_random();
    wait_idle();
    program_cfg(1'b1, 8'd1, 4'b0000);
    repeat (40) send_random();
    wait_idle();
    repeat (4) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("lcd_mode_timing_controller verification clean");
    end else begin
      $display("lcd_mode_timing_controller verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/lmtc_pkg.sv
src/lmtc_cfg.sv
src/lmtc_in_reg.sv
src/lmtc_seq.sv
src/lmtc_out_reg.sv
src/lcd_mode_timing_controller.sv
src/lmtc_checker.sv
bench/lmtc_checker.sv
bench/testbench.sv
